// ===== rtl/dhut_pkg.sv =====
// Shared types and constants of the double-hashed user table.
// No dependencies; the hash unit, the top level and the testbench import this package.
`default_nettype none

package dhut_pkg;

	// Table geometry. The hash unit relies on TABLE_PRIME being 2**SLOT_W - 1.
	localparam int TABLE_PRIME = 8191;
	localparam int SLOT_W      = 13;
	localparam int ID_W        = 31;
	localparam int COUNT_W     = 13;
	localparam int WORD_W      = ID_W + 1;   // attached flag above the key

	// Inserts stop at three quarters load whatever the register holds.
	localparam logic [COUNT_W-1:0] LOAD_CAP      = COUNT_W'((3 * TABLE_PRIME) / 4);
	localparam logic [COUNT_W-1:0] MAX_USERS_RST = COUNT_W'(6143);

	// Request codes.
	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_DETACH = 2'd2;

	// Result codes.
	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_DETACHED = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BADID    = 3'd5;

	typedef struct packed {
		logic [1:0]      func;
		logic [ID_W-1:0] user_id;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	// Probe sequence start and stride of one id.
	typedef struct packed {
		logic [SLOT_W-1:0] home;
		logic [SLOT_W-1:0] step;
	} hash_t;

endpackage

`default_nettype wire

// ===== rtl/dhut_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; holds the key and attached flag of every table slot.
`default_nettype none

module dhut_ram #(
	parameter int DEPTH = 8191,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dhut_hash.sv =====
// Home slot and probe stride of a user id, by end-around folding.
// Depends on dhut_pkg; the modulus 2**13 - 1 and 2 * (2**12 - 1) are folded.
`default_nettype none

module dhut_hash
	import dhut_pkg::*;
(
	input  wire logic [ID_W-1:0] user_id,
	output hash_t                hash
);

	localparam logic [SLOT_W:0]   PRIME_X = (SLOT_W + 1)'(TABLE_PRIME);
	localparam logic [SLOT_W-2:0] HALF_M  = '1;   // (TABLE_PRIME - 1) / 2

	logic [SLOT_W+1:0] home_f1;
	logic [SLOT_W:0]   home_f2;
	logic [ID_W-2:0]   q;
	logic [SLOT_W:0]   step_f1;
	logic [SLOT_W-1:0] step_f2;
	logic [SLOT_W-2:0] q_mod;

	always_comb begin
		// id mod (2**13 - 1): add the 13-bit digits, fold once more, one subtract.
		home_f1 = (SLOT_W + 2)'(user_id[12:0]) + (SLOT_W + 2)'(user_id[25:13])
		        + (SLOT_W + 2)'(user_id[30:26]);
		home_f2 = (SLOT_W + 1)'(home_f1[12:0]) + (SLOT_W + 1)'(home_f1[14:13]);
		if (home_f2 >= PRIME_X) begin
			hash.home = SLOT_W'(home_f2 - PRIME_X);
		end else begin
			hash.home = home_f2[SLOT_W-1:0];
		end

		// id mod 8190 = 2 * ((id >> 1) mod 4095) + id[0].
		q       = user_id[ID_W-1:1];
		step_f1 = (SLOT_W + 1)'(q[11:0]) + (SLOT_W + 1)'(q[23:12])
		        + (SLOT_W + 1)'(q[29:24]);
		step_f2 = SLOT_W'(step_f1[11:0]) + SLOT_W'(step_f1[13:12]);
		if (step_f2 >= SLOT_W'(HALF_M)) begin
			q_mod = (SLOT_W - 1)'(step_f2 - SLOT_W'(HALF_M));
		end else begin
			q_mod = step_f2[SLOT_W-2:0];
		end
		hash.step = {q_mod, user_id[0]} + SLOT_W'(1);
	end

endmodule

`default_nettype wire

// ===== rtl/double_hash_user_table_top.sv =====
// Top level of the double-hashed user table: request sequencer around the slot RAM.
// Depends on dhut_pkg, dhut_hash and dhut_ram.
//
// Usage. Requests arrive on req (func, user_id) under req_valid / req_stall; a
// transfer happens at a clock edge with req_valid high and req_stall low. Each
// request gives exactly one result on rsp (status, slot) under rsp_valid /
// rsp_stall, transferred the same way. The max_users register is written through
// cfg_valid / cfg_ready / cfg_data; cfg_ready is always high, and the register
// should be written only while no request is in flight.
//
// Timing. A request is hashed in S_HASH, which also issues the read of its home
// slot, then probes the slot RAM in S_PROBE (one read per probe, the RAM read
// port sets the pace), then posts its result from S_EMIT, where rsp_valid is set.
// The next request can be taken in the cycle after that, so the block works on
// one request at a time. A zero id skips probing. P, the number of probes of one
// request, is at most 8191.
//
// Reset. After arst_n the table is swept clear, one slot a cycle, over every
// slot, with req_stall high; the user count is zero and max_users is 6143.
//
// Back pressure. The result sits in an output register. While rsp_stall holds it,
// the block still accepts and works on the next request, and waits with that
// result done until the output register frees up.
`default_nettype none

module double_hash_user_table_top
	import dhut_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_PRIME - 1);
	localparam logic [SLOT_W:0]   PRIME_X   = (SLOT_W + 1)'(TABLE_PRIME);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  clr_addr_q;
	logic [1:0]         func_q;
	logic [ID_W-1:0]    id_q;
	logic [SLOT_W-1:0]  h_q;
	logic [SLOT_W-1:0]  step_q;
	logic [SLOT_W-1:0]  n_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] max_users_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	hash_t              hash;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [SLOT_W-1:0]  ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;

	logic [ID_W-1:0]    rd_key;
	logic               rd_att;
	logic               hit;
	logic               empty;
	logic               last_probe;
	logic               is_ins;
	logic               is_det;
	logic [COUNT_W-1:0] limit;
	logic               ins_ok;
	logic [SLOT_W:0]    h_sum;
	logic [SLOT_W-1:0]  h_next;
	logic               out_free;

	dhut_hash u_hash (
		.user_id (id_q),
		.hash    (hash)
	);

	dhut_ram #(
		.DEPTH (TABLE_PRIME),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Probe evaluation. The RAM word read for h_q is present during S_PROBE.
	always_comb begin
		rd_key     = ram_rdata[ID_W-1:0];
		rd_att     = ram_rdata[ID_W];
		hit        = (rd_key == id_q);
		empty      = (rd_key == '0);
		last_probe = (n_q == LAST_SLOT);
		is_ins     = (func_q == FUNC_INSERT);
		is_det     = (func_q == FUNC_DETACH);
		limit      = (max_users_q < LOAD_CAP) ? max_users_q : LOAD_CAP;
		ins_ok     = empty && is_ins && (count_q < limit);
		h_sum      = (SLOT_W + 1)'(h_q) + (SLOT_W + 1)'(step_q);
		if (h_sum >= PRIME_X) begin
			h_next = SLOT_W'(h_sum - PRIME_X);
		end else begin
			h_next = h_sum[SLOT_W-1:0];
		end
		out_free = !rsp_valid_q || !rsp_stall;
	end

	// RAM port control. Only one request is in flight and its write, if any, lands
	// in its last probe cycle, so a read never meets a pending write to the same
	// slot and no forwarding is needed.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = h_q;
		ram_wdata = {1'b1, id_q};
		ram_re    = 1'b0;
		ram_raddr = hash.home;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			S_HASH: begin
				ram_re = (id_q != '0);
			end
			S_PROBE: begin
				if (hit) begin
					// Detach clears the flag and keeps the key in place.
					ram_we    = is_det;
					ram_wdata = {1'b0, rd_key};
				end else if (empty) begin
					ram_we = ins_ok;
				end else if (!last_probe) begin
					ram_re    = 1'b1;
					ram_raddr = h_next;
				end
			end
			S_IDLE, S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			func_q      <= FUNC_LOOKUP;
			id_q        <= '0;
			h_q         <= '0;
			step_q      <= '0;
			n_q         <= '0;
			count_q     <= '0;
			max_users_q <= MAX_USERS_RST;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_users_q <= cfg_data;
			end

			// The output register loads a new result when it is free; otherwise
			// a held result leaves once the receiver stops stalling.
			if (state_q == S_EMIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + SLOT_W'(1);
					if (clr_addr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q  <= req.func;
						id_q    <= req.user_id;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					h_q    <= hash.home;
					step_q <= hash.step;
					n_q    <= '0;
					if (id_q == '0) begin
						res_q   <= '{status: ST_BADID, slot: '0};
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (hit) begin
						if (is_det) begin
							res_q <= '{status: ST_DETACHED, slot: h_q};
						end else begin
							res_q <= '{status: rd_att ? ST_FOUND : ST_NOTFOUND, slot: h_q};
						end
						state_q <= S_EMIT;
					end else if (empty) begin
						if (!is_ins) begin
							res_q <= '{status: ST_NOTFOUND, slot: h_q};
						end else if (ins_ok) begin
							res_q   <= '{status: ST_INSERTED, slot: h_q};
							count_q <= count_q + COUNT_W'(1);
						end else begin
							res_q <= '{status: ST_FULL, slot: h_q};
						end
						state_q <= S_EMIT;
					end else if (last_probe) begin
						// Every slot tried; the stride has wrapped back to home.
						res_q   <= '{status: is_ins ? ST_FULL : ST_NOTFOUND, slot: h_next};
						state_q <= S_EMIT;
					end else begin
						h_q <= h_next;
						n_q <= n_q + SLOT_W'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// The user count never exceeds the load cap.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LOAD_CAP)
		else $error("user count above load cap");

	// The slot RAM is written only by the clearing sweep or a probe decision.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_PROBE))
		else $error("slot RAM written outside clear or probe");

	// An accepted request always goes to hashing next.
	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_HASH))
		else $error("accepted request did not start hashing");

	// The probe pointer and stride stay inside the table.
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> (h_q < LAST_SLOT + SLOT_W'(1) && step_q != '0))
		else $error("probe slot or stride out of range");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for double_hash_user_table_top.
// Depends on dhut_pkg and the block's RTL. Contains a shadow hash table that
// predicts every result, a clocked driver and monitor, and the phase sequencer.
`timescale 1ns / 1ps

module tb_top;
	import dhut_pkg::*;

	// The request code the block does not define. It must behave like a lookup.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	// Ids this far apart share both home slot and stride, so they walk the
	// very same probe path and build long chains.
	localparam int unsigned SAME_PATH = TABLE_PRIME * (TABLE_PRIME - 1);

	// Worst realistic run: the clearing sweep after reset, plus about 1050
	// requests, each with the longest sender gap, the longest receiver stall
	// and a few dozen probes. The limit is several times that.
	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_AT_RESULT = 250;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_REPORTS = 200;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data  = '0;

	double_hash_user_table_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the table: keys, attached flags, user count and limit.
	logic [ID_W-1:0]    shadow_key [TABLE_PRIME];
	bit                 shadow_attached [TABLE_PRIME];
	logic [COUNT_W-1:0] shadow_count = '0;
	logic [COUNT_W-1:0] shadow_limit = MAX_USERS_RST;

	req_t               req_backlog_q[$];   // requests not yet offered to the block
	rsp_t               rsp_due_q[$];       // results owed by the block, oldest first
	logic [ID_W-1:0]    id_pool[$];         // ids sent for insertion, reused for hits

	int unsigned reqs_queued = 0;
	int unsigned reqs_taken  = 0;
	int unsigned rsps_seen   = 0;
	int unsigned errors      = 0;
	int unsigned cycle_count = 0;

	int unsigned req_gap = 0, req_calm = 0;
	int unsigned rsp_gap = 0, rsp_calm = 0;
	int unsigned hold_cnt = 0;
	bit          hold_done = 1'b0;

	// Applies one request to the shadow table and returns the result the
	// block must give for it. The probe walks home, home + stride, ... and
	// stops at the id or at an empty slot. If neither turns up in a full
	// cycle of the prime, the walk is back at the home slot.
	function automatic rsp_t shadow_table_apply(req_t r);
		int unsigned        pos, stride, n;
		bit                 hit, hole;
		logic [COUNT_W-1:0] cap;
		rsp_t               res;
		hit  = 1'b0;
		hole = 1'b0;
		if (r.user_id == '0) begin
			res.status = ST_BADID;
			res.slot   = '0;
			return res;
		end
		pos    = r.user_id % TABLE_PRIME;
		stride = 1 + r.user_id % (TABLE_PRIME - 1);
		n      = 0;
		while (n < TABLE_PRIME) begin
			if (shadow_key[pos] == r.user_id) begin
				hit = 1'b1;
				break;
			end
			if (shadow_key[pos] == '0) begin
				hole = 1'b1;
				break;
			end
			pos = pos + stride;
			if (pos >= TABLE_PRIME)
				pos = pos - TABLE_PRIME;
			n++;
		end
		res.slot = pos[SLOT_W-1:0];
		if (hit) begin
			// A detached key stays in place: it answers not found and is
			// never inserted again, but a detach still reports success.
			if (r.func == FUNC_DETACH) begin
				shadow_attached[pos] = 1'b0;
				res.status = ST_DETACHED;
			end else begin
				res.status = shadow_attached[pos] ? ST_FOUND : ST_NOTFOUND;
			end
		end else if (r.func != FUNC_INSERT) begin
			res.status = ST_NOTFOUND;
		end else begin
			cap = (shadow_limit < LOAD_CAP) ? shadow_limit : LOAD_CAP;
			if (!hole || shadow_count >= cap) begin
				res.status = ST_FULL;
			end else begin
				shadow_key[pos]      = r.user_id;
				shadow_attached[pos] = 1'b1;
				shadow_count         = shadow_count + 1'b1;
				res.status           = ST_INSERTED;
			end
		end
		return res;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Picks a user id. Reused ids give hits and detaches, ids on a shared
	// home slot or a shared probe path give collisions and long walks, and a
	// few ids sit at the extremes, zero included.
	function automatic logic [ID_W-1:0] pick_id();
		int unsigned r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 45 && id_pool.size() > 0) begin
			v = {1'b0, id_pool[$urandom_range(0, id_pool.size() - 1)]};
		end else if (r < 60) begin
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = 1;
				2: v = 4095;
				default: v = TABLE_PRIME - 1;
			endcase
			v = v + TABLE_PRIME * $urandom_range(1, 262143);
		end else if (r < 75) begin
			v = ($urandom_range(0, 1) ? 777 : 12345) + SAME_PATH * $urandom_range(0, 31);
		end else if (r < 96) begin
			v = $urandom_range(1, 32'h7FFF_FFFF);
		end else begin
			case (r)
				96: v = 0;
				97: v = 32'h7FFF_FFFF;
				98: v = 1;
				default: v = TABLE_PRIME;
			endcase
		end
		return v[ID_W-1:0];
	endfunction

	task automatic queue_req(input logic [1:0] f, input logic [ID_W-1:0] id);
		req_t r;
		r.func    = f;
		r.user_id = id;
		if (f == FUNC_INSERT && id != '0) begin
			id_pool.push_back(id);
			if (id_pool.size() > 400)
				void'(id_pool.pop_front());
		end
		req_backlog_q.push_back(r);
		reqs_queued++;
	endtask

	// Random requests; insert_pct sets how many are inserts, the rest are
	// mostly lookups and detaches with a few of the spare code.
	task automatic queue_random(input int unsigned count, input int unsigned insert_pct);
		int unsigned r;
		logic [1:0]  f;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < insert_pct) begin
				f = FUNC_INSERT;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					f = FUNC_LOOKUP;
				else if (r < 95)
					f = FUNC_DETACH;
				else
					f = FUNC_SPARE;
			end
			queue_req(f, pick_id());
		end
	endtask

	// Waits until every queued request has been taken and answered. Every
	// request gives one result, so the block is idle at that point.
	task automatic wait_idle();
		while (reqs_taken != reqs_queued || rsp_due_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_max_users(input logic [COUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow_limit = value;
		cfg_valid <= 1'b0;
	endtask

	// Request driver. A request stays on the bus until its transfer; the
	// shadow table is updated at the transfer so its order matches the
	// block's. Gaps are inserted between requests, with calm stretches of
	// back-to-back traffic in between.
	always @(posedge clk) begin : req_driver
		logic next_valid;
		req_t next_req;
		next_valid = req_valid;
		next_req   = req;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				rsp_due_q.push_back(shadow_table_apply(req));
				reqs_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (req_backlog_q.size() > 0) begin
					next_req   = req_backlog_q.pop_front();
					next_valid = 1'b1;
					if (req_calm > 0) begin
						req_calm--;
					end else begin
						req_gap = pick_idle();
						if ($urandom_range(0, 39) == 0)
							req_calm = $urandom_range(30, 120);
					end
				end
			end
		end
		req_valid <= next_valid;
		req       <= next_req;
	end

	// Result monitor. Each transfer is checked against the oldest owed
	// result. The stall pattern is drawn after each transfer; once, a long
	// hold-off lets the block fill up and push back on the requests.
	always @(posedge clk) begin : rsp_monitor
		rsp_t want;
		logic next_stall;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: unexpected result status %0d slot %0d",
						$time, rsp.status, rsp.slot);
			end else begin
				want = rsp_due_q.pop_front();
				if (rsp.status !== want.status || rsp.slot !== want.slot) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t ns: result %0d expected status %0d slot %0d, got status %0d slot %0d",
							$time, rsps_seen, want.status, want.slot, rsp.status, rsp.slot);
				end
			end
			rsps_seen++;
			if (rsps_seen == HOLD_AT_RESULT && !hold_done) begin
				hold_cnt  = HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (rsp_calm > 0) begin
				rsp_calm--;
			end else begin
				rsp_gap = pick_idle();
				if ($urandom_range(0, 39) == 0)
					rsp_calm = $urandom_range(30, 120);
			end
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			next_stall = 1'b1;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			next_stall = 1'b1;
		end else begin
			next_stall = 1'b0;
		end
		rsp_stall <= next_stall;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: timeout after %0d cycles", $time, cycle_count);
			$display("** double_hash_user_table_top: FAILED **");
			$finish;
		end
	end

	initial begin
		foreach (shadow_key[i])
			shadow_key[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its table after reset with requests stalled; the
		// driver simply waits for the stall to drop.
		repeat (2) @(posedge clk);
		while (req_stall)
			@(posedge clk);

		// Directed part with a limit of three ids, so the full case is reached
		// early. Ids 8191 and 16382 share home slot 0 with different strides.
		write_max_users(13'd3);
		queue_req(FUNC_LOOKUP, '0);
		queue_req(FUNC_INSERT, '0);
		queue_req(FUNC_DETACH, '0);
		queue_req(FUNC_SPARE, 31'h7FFF_FFFF);
		queue_req(FUNC_LOOKUP, 31'd1);
		queue_req(FUNC_INSERT, 31'h7FFF_FFFF);
		queue_req(FUNC_LOOKUP, 31'h7FFF_FFFF);
		queue_req(FUNC_SPARE, 31'h7FFF_FFFF);
		queue_req(FUNC_INSERT, 31'd8191);
		queue_req(FUNC_INSERT, 31'd16382);
		queue_req(FUNC_INSERT, 31'd24573);      // third on home 0, over the limit
		queue_req(FUNC_LOOKUP, 31'd24573);
		queue_req(FUNC_INSERT, 31'h7FFF_FFFF);  // already present: found, no count
		queue_req(FUNC_DETACH, 31'd16382);
		queue_req(FUNC_LOOKUP, 31'd16382);      // detached key reads as not found
		queue_req(FUNC_INSERT, 31'd16382);      // and is not inserted again
		queue_req(FUNC_DETACH, 31'd16382);      // detaching twice still succeeds
		queue_req(FUNC_DETACH, 31'd24573);      // absent id
		queue_req(FUNC_DETACH, 31'd1);
		queue_req(FUNC_LOOKUP, 31'd8191);
		queue_req(FUNC_INSERT, 31'd1);
		queue_req(FUNC_SPARE, 31'h2AAA_AAAA);
		queue_req(FUNC_LOOKUP, 31'h5555_5555);
		wait_idle();

		// A limit above the load cap, near the top of the register range; the load cap bounds the table instead.
		// The long receiver hold-off falls in this phase.
		write_max_users(13'd8190);
		queue_random(450, 40);
		wait_idle();

		// A limit just above the current count, so inserts start failing
		// partway through.
		write_max_users(shadow_count + 13'd15);
		queue_random(250, 70);
		wait_idle();

		// A limit of one, below the current count: every new insert is refused.
		write_max_users(13'd1);
		queue_random(130, 40);
		wait_idle();

		// Back to the reset value; inserts resume.
		write_max_users(MAX_USERS_RST);
		queue_random(200, 40);
		wait_idle();

		// Let any stray result show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("** double_hash_user_table_top: PASSED **");
		else
			$display("** double_hash_user_table_top: FAILED **");
		$finish;
	end

endmodule
